/* src/tsfm_pkg.sv */
// Shared types and constants of the touch sample filter and coordinate mapper.
// Field widths, configuration register indexes, status codes and reset values.
// No dependencies.
package tsfm_pkg;

   // Widths of the request, response and configuration fields.
   localparam int CONV_WORD_W = 16;
   localparam int SAMPLE_W    = 12;
   localparam int SAMPLE_LSB  = 3;
   localparam int SUM_W       = 16;
   localparam int STATUS_W    = 2;
   localparam int POS_X_W     = 9;
   localparam int POS_Y_W     = 8;
   localparam int RAW_W       = 12;
   localparam int SCALE_W     = 20;
   localparam int SCALE_FRAC  = 16;
   localparam int OFFSET_W    = 8;
   localparam int ORIENT_W    = 3;
   localparam int WINDOW_W    = 24;
   localparam int GROUP_W     = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   // Scaled products and the pixel values taken from them.
   localparam int PROD_W  = SAMPLE_W + SCALE_W;
   localparam int PIX_W   = PROD_W - SCALE_FRAC;
   localparam int COORD_W = 12;

   // Default conversions per group and the screen size in pixels.
   localparam int SAMPLES_DEFAULT = 5;
   localparam int SCREEN_WIDTH    = 320;
   localparam int SCREEN_HEIGHT   = 240;

   localparam logic [PIX_W-1:0]   X_PIX_MAX = PIX_W'(SCREEN_WIDTH - 1);
   localparam logic [PIX_W-1:0]   Y_PIX_MAX = PIX_W'(SCREEN_HEIGHT - 1);
   localparam logic [COORD_W-1:0] X_SPAN    = COORD_W'(SCREEN_WIDTH);
   localparam logic [COORD_W-1:0] Y_SPAN    = COORD_W'(SCREEN_HEIGHT);

   // A set is four groups: X, Y, X, Y.
   localparam logic [GROUP_W-1:0] LAST_GROUP = 2'd3;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK            = 2'd0,
      STATUS_PEN_UP        = 2'd1,
      STATUS_UNSTABLE      = 2'd2,
      STATUS_OUT_OF_WINDOW = 2'd3
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_X_SCALE      = 3'd0,
      CSR_Y_SCALE      = 3'd1,
      CSR_X_OFFSET     = 3'd2,
      CSR_Y_OFFSET     = 3'd3,
      CSR_ORIENTATION  = 3'd4,
      CSR_MAX_SPREAD   = 3'd5,
      CSR_RAW_X_WINDOW = 3'd6,
      CSR_RAW_Y_WINDOW = 3'd7
   } csr_index_type;

   // Screen directions.
   localparam logic [ORIENT_W-1:0] ORIENT_ROT0   = 3'd1;
   localparam logic [ORIENT_W-1:0] ORIENT_ROT90  = 3'd2;
   localparam logic [ORIENT_W-1:0] ORIENT_ROT180 = 3'd3;
   localparam logic [ORIENT_W-1:0] ORIENT_ROT270 = 3'd4;

   // Register values after reset.
   localparam logic [SCALE_W-1:0]  X_SCALE_RESET      = 20'd5243;
   localparam logic [SCALE_W-1:0]  Y_SCALE_RESET      = 20'd4588;
   localparam logic [OFFSET_W-1:0] X_OFFSET_RESET     = 8'd0;
   localparam logic [OFFSET_W-1:0] Y_OFFSET_RESET     = 8'd0;
   localparam logic [ORIENT_W-1:0] ORIENTATION_RESET  = ORIENT_ROT0;
   localparam logic [SAMPLE_W-1:0] MAX_SPREAD_RESET   = 12'd50;
   localparam logic [WINDOW_W-1:0] RAW_X_WINDOW_RESET = 24'hFFF000;
   localparam logic [WINDOW_W-1:0] RAW_Y_WINDOW_RESET = 24'hFFF000;

endpackage

/* src/tsfm_if.sv */
// Request and response channel interfaces of the touch sample filter.
// Each carries valid, ready and the payload; depends on tsfm_pkg.
interface tsfm_req_if;
   logic                             valid;
   logic                             ready;
   logic [tsfm_pkg::CONV_WORD_W-1:0] conv_word;
   logic                             pen_down;

   modport source (output valid, output conv_word, output pen_down, input ready);
   modport sink   (input valid, input conv_word, input pen_down, output ready);
endinterface

interface tsfm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tsfm_pkg::STATUS_W-1:0] status;
   logic [tsfm_pkg::POS_X_W-1:0]  pos_x;
   logic [tsfm_pkg::POS_Y_W-1:0]  pos_y;
   logic [tsfm_pkg::RAW_W-1:0]    raw_x;
   logic [tsfm_pkg::RAW_W-1:0]    raw_y;

   modport source (output valid, output status, output pos_x, output pos_y,
                   output raw_x, output raw_y, input ready);
   modport sink   (input valid, input status, input pos_x, input pos_y,
                   input raw_x, input raw_y, output ready);
endinterface

/* src/touch_sample_filter_and_map_top.sv */
// Top level of the touch sample filter and coordinate mapper.
// Filters converter words into trimmed means and maps them to screen pixels.
// Depends on tsfm_pkg and the interfaces in tsfm_if.sv.
//
// Usage:
// Each request on req_chan carries one converter word and the pen state. A set
// is four groups of SAMPLES conversions in the order X, Y, X, Y; a set starts
// only with a request that has the pen down. A request taken while no set is
// running and the pen is up gives one response with status "pen up". The last
// request of a set gives one response with the mapped position, or a status
// that reports unstable readings or a raw value outside its window. All other
// requests give no response.
// The block takes one request per clock cycle while the pipeline can accept it.
// A response appears on rsp_chan once its request has passed through the result
// pipeline (accumulate, trim, divide, spread check, window check, scale multiply,
// offset and clamp, flip). When the receiver stalls, the pipeline holds its
// results and keeps accepting requests until every stage is full; stages that
// hold nothing absorb requests, and the output stage lets go of a finished group.
// The user must write configuration registers on the csr_ port only while no
// request is in flight; the block does not enforce this. Synchronous reset
// clears the set state, empties the pipeline and loads the register defaults.
module touch_sample_filter_and_map_top #(
   parameter int SAMPLES = tsfm_pkg::SAMPLES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   tsfm_req_if.sink                         req_chan,
   tsfm_rsp_if.source                       rsp_chan,
   input  logic                             csr_write_en,
   input  logic [tsfm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tsfm_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   // The trimmed mean divides by SAMPLES-2. A reciprocal multiply with one
   // extra bit per bit of the divisor is exact for any 16-bit dividend.
   localparam int CNT_W      = $clog2(SAMPLES);
   localparam int DIVISOR    = SAMPLES - 2;
   localparam int DIV_SHIFT  = tsfm_pkg::SUM_W + $clog2(DIVISOR);
   localparam int DIV_MULT   = ((1 << DIV_SHIFT) + DIVISOR - 1) / DIVISOR;
   localparam int DIV_MULT_W = tsfm_pkg::SUM_W + 1;
   localparam int DIV_PROD_W = tsfm_pkg::SUM_W + DIV_MULT_W;
   localparam logic [DIV_MULT_W-1:0] DIV_MULT_C = DIV_MULT_W'(DIV_MULT);
   localparam logic [CNT_W-1:0]      LAST_COUNT = CNT_W'(SAMPLES - 1);

   localparam int NUM_STAGES = 8;
   localparam int OUT_STAGE  = NUM_STAGES - 1;

   // What an entry in the result pipeline stands for. A finished group that is
   // not the last of its set only writes its mean and is dropped at the end.
   typedef enum logic [1:0] {
      KIND_PEN_UP,
      KIND_GROUP,
      KIND_SET
   } kind_type;

   // Offset removal with saturation at zero, then clamping to the screen.
   function automatic logic [tsfm_pkg::COORD_W-1:0] scale_to_pixel(
      input logic [tsfm_pkg::PROD_W-1:0]   prod,
      input logic [tsfm_pkg::OFFSET_W-1:0] off,
      input logic [tsfm_pkg::PIX_W-1:0]    max_pix
   );
      logic [tsfm_pkg::PIX_W-1:0] whole;
      logic [tsfm_pkg::PIX_W-1:0] lifted;
      whole  = prod[tsfm_pkg::PROD_W-1:tsfm_pkg::SCALE_FRAC];
      lifted = (whole > tsfm_pkg::PIX_W'(off)) ? whole - tsfm_pkg::PIX_W'(off) : '0;
      if (lifted > max_pix) begin
         lifted = max_pix;
      end
      return lifted[tsfm_pkg::COORD_W-1:0];
   endfunction

   // ---------------------------------------------------------------------
   // Configuration registers.
   // ---------------------------------------------------------------------
   logic [tsfm_pkg::SCALE_W-1:0]  x_scale_ff, y_scale_ff;
   logic [tsfm_pkg::OFFSET_W-1:0] x_offset_ff, y_offset_ff;
   logic [tsfm_pkg::ORIENT_W-1:0] orientation_ff;
   logic [tsfm_pkg::SAMPLE_W-1:0] max_spread_ff;
   logic [tsfm_pkg::WINDOW_W-1:0] raw_x_window_ff, raw_y_window_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_scale_ff      <= tsfm_pkg::X_SCALE_RESET;
         y_scale_ff      <= tsfm_pkg::Y_SCALE_RESET;
         x_offset_ff     <= tsfm_pkg::X_OFFSET_RESET;
         y_offset_ff     <= tsfm_pkg::Y_OFFSET_RESET;
         orientation_ff  <= tsfm_pkg::ORIENTATION_RESET;
         max_spread_ff   <= tsfm_pkg::MAX_SPREAD_RESET;
         raw_x_window_ff <= tsfm_pkg::RAW_X_WINDOW_RESET;
         raw_y_window_ff <= tsfm_pkg::RAW_Y_WINDOW_RESET;
      end else if (csr_write_en) begin
         case (tsfm_pkg::csr_index_type'(csr_index))
            tsfm_pkg::CSR_X_SCALE: begin
               x_scale_ff <= csr_wdata[tsfm_pkg::SCALE_W-1:0];
            end
            tsfm_pkg::CSR_Y_SCALE: begin
               y_scale_ff <= csr_wdata[tsfm_pkg::SCALE_W-1:0];
            end
            tsfm_pkg::CSR_X_OFFSET: begin
               x_offset_ff <= csr_wdata[tsfm_pkg::OFFSET_W-1:0];
            end
            tsfm_pkg::CSR_Y_OFFSET: begin
               y_offset_ff <= csr_wdata[tsfm_pkg::OFFSET_W-1:0];
            end
            tsfm_pkg::CSR_ORIENTATION: begin
               orientation_ff <= csr_wdata[tsfm_pkg::ORIENT_W-1:0];
            end
            tsfm_pkg::CSR_MAX_SPREAD: begin
               max_spread_ff <= csr_wdata[tsfm_pkg::SAMPLE_W-1:0];
            end
            tsfm_pkg::CSR_RAW_X_WINDOW: begin
               raw_x_window_ff <= csr_wdata[tsfm_pkg::WINDOW_W-1:0];
            end
            tsfm_pkg::CSR_RAW_Y_WINDOW: begin
               raw_y_window_ff <= csr_wdata[tsfm_pkg::WINDOW_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline occupancy. A stage can take a new entry when it is empty or
   // when its entry moves on. The output stage also lets go of group entries,
   // which never reach the response channel.
   // ---------------------------------------------------------------------
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] take;
   kind_type              kind_ff [NUM_STAGES];
   logic                  push_in;
   kind_type              push_kind_in;

   always_comb begin
      take[OUT_STAGE] = !valid_ff[OUT_STAGE] || rsp_chan.ready ||
                        (kind_ff[OUT_STAGE] == KIND_GROUP);
      for (int k = OUT_STAGE - 1; k >= 0; k--) begin
         take[k] = !valid_ff[k] || take[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (take[0]) begin
            valid_ff[0] <= push_in;
         end
         for (int k = 1; k < NUM_STAGES; k++) begin
            if (take[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take[0]) begin
         kind_ff[0] <= push_kind_in;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
         if (take[k]) begin
            kind_ff[k] <= kind_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stage 0: running sum, maximum and minimum of the current group.
   // ---------------------------------------------------------------------
   logic                          accept;
   logic [tsfm_pkg::SAMPLE_W-1:0] sample;
   logic                          set_active_ff, set_active_in;
   logic [tsfm_pkg::GROUP_W-1:0]  group_index_ff, group_index_in;
   logic [CNT_W-1:0]              sample_count_ff, sample_count_in;
   logic [tsfm_pkg::SUM_W-1:0]    group_sum_ff, group_sum_in, sum_add;
   logic [tsfm_pkg::SAMPLE_W-1:0] group_max_ff, group_max_in, max_new;
   logic [tsfm_pkg::SAMPLE_W-1:0] group_min_ff, group_min_in, min_new;

   // Bit 15 of the converter word is dropped and the rest shifted right by 3.
   assign sample         = req_chan.conv_word[tsfm_pkg::SAMPLE_LSB +: tsfm_pkg::SAMPLE_W];
   assign accept         = req_chan.valid && take[0];
   assign req_chan.ready = take[0];

   assign sum_add = group_sum_ff + tsfm_pkg::SUM_W'(sample);
   assign max_new = (sample > group_max_ff) ? sample : group_max_ff;
   assign min_new = (sample < group_min_ff) ? sample : group_min_ff;

   always_comb begin
      set_active_in   = set_active_ff;
      group_index_in  = group_index_ff;
      sample_count_in = sample_count_ff;
      group_sum_in    = group_sum_ff;
      group_max_in    = group_max_ff;
      group_min_in    = group_min_ff;
      push_in         = 1'b0;
      push_kind_in    = KIND_PEN_UP;
      if (accept) begin
         if (!set_active_ff && !req_chan.pen_down) begin
            // Pen up between sets: report it and drop the word.
            push_in = 1'b1;
         end else if (sample_count_ff == LAST_COUNT) begin
            // Group complete: hand its sum, maximum and minimum downstream.
            push_in         = 1'b1;
            push_kind_in    = (group_index_ff == tsfm_pkg::LAST_GROUP) ? KIND_SET
                                                                       : KIND_GROUP;
            set_active_in   = (group_index_ff != tsfm_pkg::LAST_GROUP);
            group_index_in  = group_index_ff + 1'b1;
            sample_count_in = '0;
            group_sum_in    = '0;
            group_max_in    = '0;
            group_min_in    = '1;
         end else begin
            set_active_in   = 1'b1;
            sample_count_in = sample_count_ff + 1'b1;
            group_sum_in    = sum_add;
            group_max_in    = max_new;
            group_min_in    = min_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_active_ff   <= 1'b0;
         group_index_ff  <= '0;
         sample_count_ff <= '0;
         group_sum_ff    <= '0;
         group_max_ff    <= '0;
         group_min_ff    <= '1;
      end else begin
         set_active_ff   <= set_active_in;
         group_index_ff  <= group_index_in;
         sample_count_ff <= sample_count_in;
         group_sum_ff    <= group_sum_in;
         group_max_ff    <= group_max_in;
         group_min_ff    <= group_min_in;
      end
   end

   logic [tsfm_pkg::GROUP_W-1:0]  gidx0_ff, gidx1_ff, gidx2_ff;
   logic [tsfm_pkg::SUM_W-1:0]    sum0_ff;
   logic [tsfm_pkg::SAMPLE_W-1:0] max0_ff, min0_ff;

   always_ff @(posedge clock) begin
      if (take[0]) begin
         gidx0_ff <= group_index_ff;
         sum0_ff  <= sum_add;
         max0_ff  <= max_new;
         min0_ff  <= min_new;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: drop the largest and smallest sample of the group.
   // Stage 2: divide by SAMPLES-2 through the reciprocal multiply.
   // ---------------------------------------------------------------------
   logic [tsfm_pkg::SUM_W-1:0]    trim1_ff;
   logic [DIV_PROD_W-1:0]         div_prod;
   logic [tsfm_pkg::SAMPLE_W-1:0] mean2_ff;

   always_ff @(posedge clock) begin
      if (take[1]) begin
         gidx1_ff <= gidx0_ff;
         trim1_ff <= sum0_ff - tsfm_pkg::SUM_W'(max0_ff) - tsfm_pkg::SUM_W'(min0_ff);
      end
   end

   assign div_prod = DIV_PROD_W'(trim1_ff) * DIV_PROD_W'(DIV_MULT_C);

   always_ff @(posedge clock) begin
      if (take[2]) begin
         gidx2_ff <= gidx1_ff;
         mean2_ff <= div_prod[DIV_SHIFT +: tsfm_pkg::SAMPLE_W];
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: store the first three means; on the last group compare the
   // two means of each axis and average them.
   // ---------------------------------------------------------------------
   logic [tsfm_pkg::SAMPLE_W-1:0] group_means_ff [3];
   logic [tsfm_pkg::SAMPLE_W-1:0] diff_x, diff_y;
   logic [tsfm_pkg::SAMPLE_W:0]   pair_x, pair_y;
   logic                          unstable3_ff;
   logic [tsfm_pkg::SAMPLE_W-1:0] avg_x3_ff, avg_y3_ff;

   always_ff @(posedge clock) begin
      if (valid_ff[2] && take[3] && (kind_ff[2] == KIND_GROUP)) begin
         group_means_ff[gidx2_ff] <= mean2_ff;
      end
   end

   assign diff_x = (group_means_ff[0] >= group_means_ff[2])
                   ? group_means_ff[0] - group_means_ff[2]
                   : group_means_ff[2] - group_means_ff[0];
   assign diff_y = (group_means_ff[1] >= mean2_ff) ? group_means_ff[1] - mean2_ff
                                                   : mean2_ff - group_means_ff[1];
   assign pair_x = {1'b0, group_means_ff[0]} + {1'b0, group_means_ff[2]};
   assign pair_y = {1'b0, group_means_ff[1]} + {1'b0, mean2_ff};

   always_ff @(posedge clock) begin
      if (take[3]) begin
         unstable3_ff <= (diff_x > max_spread_ff) || (diff_y > max_spread_ff);
         avg_x3_ff    <= pair_x[tsfm_pkg::SAMPLE_W:1];
         avg_y3_ff    <= pair_y[tsfm_pkg::SAMPLE_W:1];
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: swap the axes for the screen direction and check the windows.
   // Any direction code other than 1 and 3 swaps the axes.
   // ---------------------------------------------------------------------
   logic                          keep_axes;
   logic [tsfm_pkg::RAW_W-1:0]    swap_x, swap_y;
   logic                          out_of_window;
   tsfm_pkg::status_type          status_in;
   tsfm_pkg::status_type          status4_ff, status5_ff, status6_ff, status7_ff;
   logic [tsfm_pkg::RAW_W-1:0]    raw_x4_ff, raw_y4_ff, raw_x5_ff, raw_y5_ff;
   logic [tsfm_pkg::RAW_W-1:0]    raw_x6_ff, raw_y6_ff, raw_x7_ff, raw_y7_ff;

   assign keep_axes = (orientation_ff == tsfm_pkg::ORIENT_ROT0) ||
                      (orientation_ff == tsfm_pkg::ORIENT_ROT180);
   assign swap_x    = keep_axes ? avg_x3_ff : avg_y3_ff;
   assign swap_y    = keep_axes ? avg_y3_ff : avg_x3_ff;

   assign out_of_window =
      (swap_x > raw_x_window_ff[tsfm_pkg::WINDOW_W-1:tsfm_pkg::RAW_W]) ||
      (swap_x < raw_x_window_ff[tsfm_pkg::RAW_W-1:0]) ||
      (swap_y > raw_y_window_ff[tsfm_pkg::WINDOW_W-1:tsfm_pkg::RAW_W]) ||
      (swap_y < raw_y_window_ff[tsfm_pkg::RAW_W-1:0]);

   always_comb begin
      if (kind_ff[3] == KIND_PEN_UP) begin
         status_in = tsfm_pkg::STATUS_PEN_UP;
      end else if (unstable3_ff) begin
         status_in = tsfm_pkg::STATUS_UNSTABLE;
      end else if (out_of_window) begin
         status_in = tsfm_pkg::STATUS_OUT_OF_WINDOW;
      end else begin
         status_in = tsfm_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (take[4]) begin
         status4_ff <= status_in;
         raw_x4_ff  <= swap_x;
         raw_y4_ff  <= swap_y;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 5: multiply by the Q4.16 scale factors.
   // Stage 6: drop the fraction, remove the offsets and clamp.
   // ---------------------------------------------------------------------
   logic [tsfm_pkg::PROD_W-1:0]  prod_x5_ff, prod_y5_ff;
   logic [tsfm_pkg::COORD_W-1:0] pix_x6_ff, pix_y6_ff;

   always_ff @(posedge clock) begin
      if (take[5]) begin
         status5_ff <= status4_ff;
         raw_x5_ff  <= raw_x4_ff;
         raw_y5_ff  <= raw_y4_ff;
         prod_x5_ff <= tsfm_pkg::PROD_W'(raw_x4_ff) * tsfm_pkg::PROD_W'(x_scale_ff);
         prod_y5_ff <= tsfm_pkg::PROD_W'(raw_y4_ff) * tsfm_pkg::PROD_W'(y_scale_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (take[6]) begin
         status6_ff <= status5_ff;
         raw_x6_ff  <= raw_x5_ff;
         raw_y6_ff  <= raw_y5_ff;
         pix_x6_ff  <= scale_to_pixel(prod_x5_ff, x_offset_ff, tsfm_pkg::X_PIX_MAX);
         pix_y6_ff  <= scale_to_pixel(prod_y5_ff, y_offset_ff, tsfm_pkg::Y_PIX_MAX);
      end
   end

   // ---------------------------------------------------------------------
   // Stage 7: flip per screen direction and form the response. Only a good
   // set reports a position; pen up and unstable sets report no raw values.
   // ---------------------------------------------------------------------
   logic                         flip_x, flip_y, show_pos, show_raw;
   logic [tsfm_pkg::COORD_W-1:0] flip_x_val, flip_y_val;
   logic [tsfm_pkg::POS_X_W-1:0] pos_x7_ff;
   logic [tsfm_pkg::POS_Y_W-1:0] pos_y7_ff;

   assign flip_x   = (orientation_ff == tsfm_pkg::ORIENT_ROT180) ||
                     (orientation_ff == tsfm_pkg::ORIENT_ROT270);
   assign flip_y   = (orientation_ff == tsfm_pkg::ORIENT_ROT0) ||
                     (orientation_ff == tsfm_pkg::ORIENT_ROT270);
   assign show_pos = (status6_ff == tsfm_pkg::STATUS_OK);
   assign show_raw = (status6_ff == tsfm_pkg::STATUS_OK) ||
                     (status6_ff == tsfm_pkg::STATUS_OUT_OF_WINDOW);

   assign flip_x_val = flip_x ? tsfm_pkg::X_SPAN - pix_x6_ff : pix_x6_ff;
   assign flip_y_val = flip_y ? tsfm_pkg::Y_SPAN - pix_y6_ff : pix_y6_ff;

   always_ff @(posedge clock) begin
      if (take[OUT_STAGE]) begin
         status7_ff <= status6_ff;
         pos_x7_ff  <= show_pos ? flip_x_val[tsfm_pkg::POS_X_W-1:0] : '0;
         pos_y7_ff  <= show_pos ? flip_y_val[tsfm_pkg::POS_Y_W-1:0] : '0;
         raw_x7_ff  <= show_raw ? raw_x6_ff : '0;
         raw_y7_ff  <= show_raw ? raw_y6_ff : '0;
      end
   end

   assign rsp_chan.valid  = valid_ff[OUT_STAGE] && (kind_ff[OUT_STAGE] != KIND_GROUP);
   assign rsp_chan.status = status7_ff;
   assign rsp_chan.pos_x  = pos_x7_ff;
   assign rsp_chan.pos_y  = pos_y7_ff;
   assign rsp_chan.raw_x  = raw_x7_ff;
   assign rsp_chan.raw_y  = raw_y7_ff;

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------

   // Between sets the group accumulators are always back at their clear values.
   a_idle_accum_clear : assert property (@(posedge clock) disable iff (reset)
      !set_active_ff |-> (sample_count_ff == '0) && (group_sum_ff == '0) &&
                         (group_max_ff == '0) && (group_min_ff == '1))
      else $error("accumulators not cleared outside a set");

   // A pen-up request between sets is queued as a pen-up entry and starts no set.
   a_pen_up_queued : assert property (@(posedge clock) disable iff (reset)
      accept && !set_active_ff && !req_chan.pen_down |=>
         valid_ff[0] && (kind_ff[0] == KIND_PEN_UP) && !set_active_ff)
      else $error("pen-up request not handled as a pen-up entry");

   // Only a good set carries a screen position.
   a_no_pos_on_error : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.status != tsfm_pkg::STATUS_OK) |->
         (rsp_chan.pos_x == '0) && (rsp_chan.pos_y == '0))
      else $error("position reported with a failing status");

endmodule

/* tb/tb_touch_sample_filter_and_map_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the touch sample filter and coordinate mapper.
// Depends on tsfm_pkg, the channel interfaces in tsfm_if.sv and the top level,
// which it drives with random sets, pen-up requests and register settings.
module tb_touch_sample_filter_and_map_top;
   import tsfm_pkg::*;

   // Conversions per group; the block is built with the same count.
   localparam int CONVS_PER_GROUP = SAMPLES_DEFAULT;
   localparam int RAW_MAX         = 4095;
   // The random part stops once about this many requests have been queued.
   localparam int TARGET_REQUESTS = 1850;
   localparam int PHASE_REQUESTS  = 150;
   // Latency of the result pipeline plus some margin; used before register
   // writes and at the end, when a set may still be in flight.
   localparam int PIPE_LATENCY  = 8;
   localparam int SETTLE_CYCLES = PIPE_LATENCY + 4;
   // Length of the long receiver hold-off that fills the pipeline.
   localparam int LONG_HOLD_CYCLES = 400;
   // A raw window that accepts every value: maximum 4095, minimum 0.
   localparam logic [WINDOW_W-1:0] WINDOW_ALL = 24'hFFF000;
   // Orientation codes outside 1..4; they act as a quarter turn without flips.
   localparam logic [ORIENT_W-1:0] ORIENT_ALIASES [4] = '{3'd0, 3'd5, 3'd6, 3'd7};

   typedef struct packed {
      status_type         status;
      logic [POS_X_W-1:0] pos_x;
      logic [POS_Y_W-1:0] pos_y;
      logic [RAW_W-1:0]   raw_x;
      logic [RAW_W-1:0]   raw_y;
   } touch_result_t;

   typedef struct {
      logic [CONV_WORD_W-1:0] word;
      logic                   pen;
      // The sender holds this request back until every result is in.
      bit                     drain_first;
   } touch_request_t;

   typedef struct {
      logic [SCALE_W-1:0]  x_scale;
      logic [SCALE_W-1:0]  y_scale;
      logic [OFFSET_W-1:0] x_offset;
      logic [OFFSET_W-1:0] y_offset;
      logic [ORIENT_W-1:0] orientation;
      logic [SAMPLE_W-1:0] max_spread;
      logic [WINDOW_W-1:0] raw_x_window;
      logic [WINDOW_W-1:0] raw_y_window;
   } map_cfg_t;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index    = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata    = '0;

   tsfm_req_if req_chan ();
   tsfm_rsp_if rsp_chan ();

   touch_sample_filter_and_map_top #(
      .SAMPLES (CONVS_PER_GROUP)
   ) u_top (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Requests waiting to be offered and results waiting to come back.
   touch_request_t pending_requests [$];
   touch_result_t  touch_results_due [$];
   int             requests_queued = 0;
   int             error_count     = 0;

   // ------------------------------------------------------------------------
   // Predictor. It holds its own copy of the register settings and of the set
   // state, and is stepped once for every request the block accepts.
   // ------------------------------------------------------------------------
   map_cfg_t map_cfg = '{
      x_scale: X_SCALE_RESET, y_scale: Y_SCALE_RESET,
      x_offset: X_OFFSET_RESET, y_offset: Y_OFFSET_RESET,
      orientation: ORIENTATION_RESET, max_spread: MAX_SPREAD_RESET,
      raw_x_window: RAW_X_WINDOW_RESET, raw_y_window: RAW_Y_WINDOW_RESET};

   bit                  set_busy   = 1'b0;
   logic [GROUP_W-1:0]  axis_group = '0;
   int                  conv_count = 0;
   logic [SUM_W-1:0]    conv_sum   = '0;
   logic [SAMPLE_W-1:0] conv_max   = '0;
   logic [SAMPLE_W-1:0] conv_min   = '1;
   logic [SAMPLE_W-1:0] axis_means [3] = '{default: '0};

   task automatic restart_group();
      conv_count = 0;
      conv_sum   = '0;
      conv_max   = '0;
      conv_min   = '1;
   endtask

   function automatic logic [SAMPLE_W-1:0] mean_gap(logic [SAMPLE_W-1:0] a,
                                                    logic [SAMPLE_W-1:0] b);
      return (a >= b) ? a - b : b - a;
   endfunction

   // Pixel from a raw value: integer part of raw * factor, minus the offset
   // with a floor of zero, then clamped to the last pixel of the axis.
   function automatic logic [31:0] scale_pixel(logic [RAW_W-1:0] raw,
                                               logic [SCALE_W-1:0] factor,
                                               logic [OFFSET_W-1:0] offset_px,
                                               int unsigned limit);
      logic [31:0] pixel;
      pixel = (32'(raw) * 32'(factor)) >> SCALE_FRAC;
      pixel = (pixel > 32'(offset_px)) ? pixel - 32'(offset_px) : '0;
      if (pixel > limit - 1)
         pixel = limit - 1;
      return pixel;
   endfunction

   task automatic predict_touch_result(logic [CONV_WORD_W-1:0] word, logic pen);
      logic [SAMPLE_W-1:0] conv, mean, x0, y0, x1, y1, ax, ay, rx, ry;
      logic [31:0]         px, py;
      bit                  keep_axes;
      touch_result_t       res;
      conv = word[14:SAMPLE_LSB];
      res  = '0;
      if (!set_busy) begin
         // With no set running, a pen-up request is answered at once.
         if (!pen) begin
            res.status = STATUS_PEN_UP;
            touch_results_due.push_back(res);
            return;
         end
         set_busy   = 1'b1;
         axis_group = '0;
         restart_group();
      end
      conv_sum = conv_sum + SUM_W'(conv);
      if (conv > conv_max)
         conv_max = conv;
      if (conv < conv_min)
         conv_min = conv;
      conv_count++;
      if (conv_count < CONVS_PER_GROUP)
         return;
      mean = SAMPLE_W'((conv_sum - SUM_W'(conv_max) - SUM_W'(conv_min))
                       / (CONVS_PER_GROUP - 2));
      restart_group();
      if (axis_group != LAST_GROUP) begin
         axis_means[axis_group] = mean;
         axis_group++;
         return;
      end
      set_busy   = 1'b0;
      axis_group = '0;
      x0 = axis_means[0];
      y0 = axis_means[1];
      x1 = axis_means[2];
      y1 = mean;
      if (mean_gap(x0, x1) > map_cfg.max_spread || mean_gap(y0, y1) > map_cfg.max_spread) begin
         res.status = STATUS_UNSTABLE;
         touch_results_due.push_back(res);
         return;
      end
      ax = SAMPLE_W'((13'(x0) + 13'(x1)) >> 1);
      ay = SAMPLE_W'((13'(y0) + 13'(y1)) >> 1);
      keep_axes = (map_cfg.orientation == ORIENT_ROT0) ||
                  (map_cfg.orientation == ORIENT_ROT180);
      rx = keep_axes ? ax : ay;
      ry = keep_axes ? ay : ax;
      res.raw_x = rx;
      res.raw_y = ry;
      if (rx > map_cfg.raw_x_window[23:12] || rx < map_cfg.raw_x_window[11:0] ||
          ry > map_cfg.raw_y_window[23:12] || ry < map_cfg.raw_y_window[11:0]) begin
         res.status = STATUS_OUT_OF_WINDOW;
         touch_results_due.push_back(res);
         return;
      end
      px = scale_pixel(rx, map_cfg.x_scale, map_cfg.x_offset, SCREEN_WIDTH);
      py = scale_pixel(ry, map_cfg.y_scale, map_cfg.y_offset, SCREEN_HEIGHT);
      if (map_cfg.orientation == ORIENT_ROT0 || map_cfg.orientation == ORIENT_ROT270)
         py = SCREEN_HEIGHT - py;
      if (map_cfg.orientation == ORIENT_ROT180 || map_cfg.orientation == ORIENT_ROT270)
         px = SCREEN_WIDTH - px;
      res.status = STATUS_OK;
      res.pos_x  = POS_X_W'(px);
      res.pos_y  = POS_Y_W'(py);
      touch_results_due.push_back(res);
   endtask

   // ------------------------------------------------------------------------
   // Request driver. It works in bursts of random length separated by random
   // gaps, holds a request steady until it is taken, and feeds the predictor
   // at the edge where a request is accepted.
   // ------------------------------------------------------------------------
   touch_request_t next_req;
   int             burst_left = 0;
   int             gap_left   = 0;
   bit             offering;

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         offering = req_chan.valid && !req_chan.ready;
         if (req_chan.valid && req_chan.ready)
            predict_touch_result(req_chan.conv_word, req_chan.pen_down);
         if (!offering) begin
            if (gap_left > 0) begin
               gap_left--;
               req_chan.valid <= 1'b0;
            end else if (pending_requests.size() != 0 &&
                         !(pending_requests[0].drain_first &&
                           touch_results_due.size() != 0)) begin
               next_req = pending_requests.pop_front();
               req_chan.conv_word <= next_req.word;
               req_chan.pen_down  <= next_req.pen;
               req_chan.valid     <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  // About one burst in four runs straight into the next one.
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
               end
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response monitor. It checks every accepted response against the oldest
   // prediction and drives ready on a stall pattern of its own: stretches of
   // always ready, coin flips, rare ready and a fixed rhythm. The stimulus
   // process can also order a long hold-off, counted here in cycles.
   // ------------------------------------------------------------------------
   int            hold_orders  = 0;
   int            holds_served = 0;
   int            hold_left    = 0;
   int            stall_style  = 0;
   int            style_left   = 0;
   int            rsp_cycle    = 0;
   touch_result_t want;

   task automatic check_field(string name, logic [15:0] exp, logic [15:0] act);
      if (act !== exp) begin
         $error("%s mismatch: expected %0d, actual %0d", name, exp, act);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (touch_results_due.size() == 0) begin
               $error("response with no request behind it: status %0d raw %0d/%0d",
                      rsp_chan.status, rsp_chan.raw_x, rsp_chan.raw_y);
               error_count++;
            end else begin
               want = touch_results_due.pop_front();
               check_field("status", 16'(want.status), 16'(rsp_chan.status));
               check_field("pos_x", 16'(want.pos_x), 16'(rsp_chan.pos_x));
               check_field("pos_y", 16'(want.pos_y), 16'(rsp_chan.pos_y));
               check_field("raw_x", 16'(want.raw_x), 16'(rsp_chan.raw_x));
               check_field("raw_y", 16'(want.raw_y), 16'(rsp_chan.raw_y));
            end
         end
         if (holds_served != hold_orders) begin
            holds_served++;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (style_left == 0) begin
            stall_style = $urandom_range(0, 3);
            style_left  = $urandom_range(32, 256);
         end else begin
            style_left--;
         end
         rsp_cycle++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            case (stall_style)
               0: rsp_chan.ready <= 1'b1;
               1: rsp_chan.ready <= 1'($urandom_range(0, 1));
               2: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_chan.ready <= (rsp_cycle % 3 != 0);
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus generation.
   // ------------------------------------------------------------------------

   // Converter word carrying a 12-bit conversion; the stray top bit and the
   // three low bits are random, since the block must drop them.
   function automatic logic [CONV_WORD_W-1:0] conv_word_for(logic [SAMPLE_W-1:0] conv);
      return {1'($urandom), conv, 3'($urandom)};
   endfunction

   task automatic push_request(logic [CONV_WORD_W-1:0] word, logic pen);
      touch_request_t r;
      r.word        = word;
      r.pen         = pen;
      r.drain_first = ($urandom_range(0, 149) == 0);
      pending_requests.push_back(r);
      requests_queued++;
   endtask

   // One group of conversions around a center value. Most conversions sit
   // at it or just above it; the rest are outliers that the trimming has to remove,
   // or that shift the mean when two land on the same side.
   task automatic push_group(int centre, bit opens_set);
      int v;
      for (int s = 0; s < CONVS_PER_GROUP; s++) begin
         case ($urandom_range(0, 9))
            7, 8: v = $urandom_range(0, RAW_MAX);
            9: v = $urandom_range(0, 1) * RAW_MAX;
            default: v = centre + $urandom_range(0, 2);
         endcase
         if (v > RAW_MAX)
            v = RAW_MAX;
         // Only the opening request needs the pen down; later ones are ignored.
         push_request(conv_word_for(SAMPLE_W'(v)), (opens_set && s == 0) ? 1'b1 : 1'($urandom));
      end
   endtask

   // Center of the second group of an axis: mostly within the allowed spread,
   // sometimes right at it or one past it, sometimes anywhere.
   function automatic int partner_mean(int base, int spread);
      int d;
      case ($urandom_range(0, 9))
         6: d = spread;
         7: d = spread + 1;
         8, 9: d = $urandom_range(0, RAW_MAX);
         default: d = $urandom_range(0, spread);
      endcase
      if (base + d <= RAW_MAX)
         return base + d;
      if (base >= d)
         return base - d;
      return RAW_MAX;
   endfunction

   task automatic push_random_set();
      int x0, y0;
      x0 = $urandom_range(0, RAW_MAX);
      y0 = $urandom_range(0, RAW_MAX);
      push_group(x0, 1'b1);
      push_group(y0, 1'b0);
      push_group(partner_mean(x0, map_cfg.max_spread), 1'b0);
      push_group(partner_mean(y0, map_cfg.max_spread), 1'b0);
   endtask

   // Whole sets mixed with short runs of pen-up requests, so that every
   // phase ends with no set running.
   task automatic push_random_traffic(int count);
      int start;
      start = requests_queued;
      while (requests_queued - start < count) begin
         if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 4)) push_request(16'($urandom), 1'b0);
         else
            push_random_set();
      end
   endtask

   // Opening requests: pen-up words at both extremes, then one set whose X
   // groups read full scale and whose Y groups read zero, with the pen
   // released inside the set and the dropped bits set and cleared.
   task automatic push_directed();
      logic [CONV_WORD_W-1:0] high_words [5] = '{16'hFFFF, 16'h7FF8, 16'hFFFA, 16'h7FFF, 16'hFFF8};
      logic [CONV_WORD_W-1:0] low_words [5]  = '{16'h0000, 16'h8000, 16'h0007, 16'h8005, 16'h0001};
      logic                   pen_pattern [5] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
      push_request(16'h0000, 1'b0);
      push_request(16'hFFFF, 1'b0);
      for (int g = 0; g < 4; g++)
         for (int s = 0; s < CONVS_PER_GROUP; s++)
            push_request((g % 2 == 0) ? high_words[s] : low_words[s], pen_pattern[s]);
      push_request(16'h5555, 1'b0);
      push_request(16'hAAAA, 1'b0);
   endtask

   function automatic logic [WINDOW_W-1:0] random_window();
      logic [SAMPLE_W-1:0] lo, hi;
      case ($urandom_range(0, 9))
         6, 7, 8: begin
            lo = SAMPLE_W'($urandom_range(0, 2000));
            hi = SAMPLE_W'($urandom_range(2000, RAW_MAX));
            return {hi, lo};
         end
         // Fully random, so the minimum often lies above the maximum.
         9: return WINDOW_W'($urandom);
         default: return WINDOW_ALL;
      endcase
   endfunction

   function automatic map_cfg_t random_map_cfg();
      map_cfg_t c;
      // Scale factors mostly near a useful range, sometimes anywhere.
      c.x_scale = ($urandom_range(0, 3) == 0) ? SCALE_W'($urandom)
                                               : SCALE_W'($urandom_range(2000, 12000));
      c.y_scale = ($urandom_range(0, 3) == 0) ? SCALE_W'($urandom)
                                               : SCALE_W'($urandom_range(2000, 12000));
      c.x_offset = ($urandom_range(0, 2) == 0) ? '0 : OFFSET_W'($urandom);
      c.y_offset = ($urandom_range(0, 2) == 0) ? '0 : OFFSET_W'($urandom);
      c.orientation = ($urandom_range(0, 7) == 0) ? ORIENT_W'($urandom)
                         : ORIENT_W'($urandom_range(ORIENT_ROT0, ORIENT_ROT270));
      c.max_spread = ($urandom_range(0, 1) == 0) ? SAMPLE_W'($urandom_range(0, 100))
                                                  : SAMPLE_W'($urandom);
      c.raw_x_window = random_window();
      c.raw_y_window = random_window();
      return c;
   endfunction

   task automatic csr_write(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
   endtask

   // Writes all eight registers on consecutive edges. Bits above a register's
   // width carry junk, which the block must ignore.
   task automatic write_map_cfg(map_cfg_t c);
      csr_write(CSR_X_SCALE, {4'($urandom), c.x_scale});
      csr_write(CSR_Y_SCALE, {4'($urandom), c.y_scale});
      csr_write(CSR_X_OFFSET, {16'($urandom), c.x_offset});
      csr_write(CSR_Y_OFFSET, {16'($urandom), c.y_offset});
      csr_write(CSR_ORIENTATION, {21'($urandom), c.orientation});
      csr_write(CSR_MAX_SPREAD, {12'($urandom), c.max_spread});
      csr_write(CSR_RAW_X_WINDOW, c.raw_x_window);
      csr_write(CSR_RAW_Y_WINDOW, c.raw_y_window);
      @(posedge clock);
      csr_write_en <= 1'b0;
      map_cfg = c;
      @(negedge clock);
   endtask

   // Waits at falling edges until every request is taken and every predicted
   // result is in, then lets the pipeline settle in case a request that gives
   // no result is still moving through it.
   task automatic wait_until_drained();
      while (pending_requests.size() != 0 || req_chan.valid || touch_results_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Main sequence: reset, then phases, each with its own register setting.
   // The first phase runs on the reset values, the next few pin the extremes
   // and the unused orientation codes, and the rest are random.
   initial begin
      map_cfg_t next_cfg;
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.conv_word = '0;
      req_chan.pen_down  = 1'b0;
      rsp_chan.ready     = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int p = 0; p < 9 || requests_queued < TARGET_REQUESTS; p++) begin
         wait_until_drained();
         if (p > 0) begin
            next_cfg = random_map_cfg();
            case (p)
               1: next_cfg = '{x_scale: '1, y_scale: '1, x_offset: '0, y_offset: '1,
                               orientation: ORIENT_ROT90, max_spread: '1,
                               raw_x_window: WINDOW_ALL, raw_y_window: WINDOW_ALL};
               2: next_cfg = '{x_scale: '0, y_scale: '0, x_offset: '1, y_offset: '1,
                               orientation: ORIENT_ROT180, max_spread: '0,
                               raw_x_window: WINDOW_ALL, raw_y_window: WINDOW_ALL};
               3: next_cfg = '{x_scale: X_SCALE_RESET, y_scale: Y_SCALE_RESET,
                               x_offset: 8'd20, y_offset: 8'd10,
                               orientation: ORIENT_ROT270, max_spread: MAX_SPREAD_RESET,
                               raw_x_window: {12'd3000, 12'd1000},
                               raw_y_window: {12'd3500, 12'd500}};
               4: begin
                  // Minimum above maximum: every complete set falls outside.
                  next_cfg.orientation  = ORIENT_ALIASES[0];
                  next_cfg.max_spread   = '1;
                  next_cfg.raw_x_window = {12'd100, 12'd200};
               end
               5, 6, 7: next_cfg.orientation = ORIENT_ALIASES[p - 4];
               default: ;
            endcase
            write_map_cfg(next_cfg);
         end
         // In two phases the receiver holds off for a long stretch while a
         // run of pen-up requests keeps coming, so the block fills and stalls.
         if (p == 2 || p == 8) begin
            hold_orders++;
            repeat (30) push_request(16'($urandom), 1'b0);
         end
         if (p == 0)
            push_directed();
         push_random_traffic(PHASE_REQUESTS);
      end

      wait_until_drained();
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Hard limit on the run, many times the slowest correct run.
   initial begin
      #4_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
